// File: rtl/core/clcd_pkg.sv
`default_nettype none

package clcd_pkg;

   // Request kinds as carried on the input channel.
   typedef enum logic [2:0] {
      KIND_CMD    = 3'd0,
      KIND_DATA   = 3'd1,
      KIND_INIT   = 3'd2,
      KIND_CURSOR = 3'd3,
      KIND_GLYPH  = 3'd4,
      KIND_CLEAR  = 3'd5
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_PULSE_WIDTH = 2'd0,
      CSR_SETTLE      = 2'd1,
      CSR_LONG_WAIT   = 2'd2
   } csr_index_type;

   // Extra wait added on top of the settle time after a pulse.
   typedef enum logic [2:0] {
      EXTRA_NONE  = 3'd0,
      EXTRA_WAKE1 = 3'd1,
      EXTRA_WAKE2 = 3'd2,
      EXTRA_LONG1 = 3'd3,
      EXTRA_LONG2 = 3'd4
   } extra_type;

   // Field widths.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned NIBBLE_W = 4;
   localparam int unsigned WAIT_W   = 15;
   localparam int unsigned PULSE_W  = 8;
   localparam int unsigned SETTLE_W = 10;
   localparam int unsigned LONG_W   = 13;
   localparam int unsigned STEP_W   = 4;

   // Configuration reset values.
   localparam logic [PULSE_W-1:0]  PULSE_WIDTH_RESET = 8'd5;
   localparam logic [SETTLE_W-1:0] SETTLE_RESET      = 10'd100;
   localparam logic [LONG_W-1:0]   LONG_WAIT_RESET   = 13'd2000;

   // LCD command bytes.
   localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_HOME      = 8'h02;
   localparam logic [BYTE_W-1:0] LINE1_BASE    = 8'h80;
   localparam logic [BYTE_W-1:0] LINE2_BASE    = 8'hC0;
   localparam logic [BYTE_W-1:0] CGRAM_BASE    = 8'h40;
   localparam logic [BYTE_W-1:0] CMD_FUNC_4BIT = 8'h28;
   localparam logic [BYTE_W-1:0] CMD_DISPLAY   = 8'h0C;
   localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;

   // Wake-up sequence timing and nibbles.
   localparam logic [WAIT_W-1:0]   POWER_UP_WAIT = 15'd20000;
   localparam logic [WAIT_W-1:0]   WAKE_WAIT1    = 15'd5000;
   localparam logic [WAIT_W-1:0]   WAKE_WAIT2    = 15'd150;
   localparam logic [NIBBLE_W-1:0] WAKE_NIBBLE   = 4'h3;
   localparam logic [NIBBLE_W-1:0] BUS4_NIBBLE   = 4'h2;

   // Step numbers inside the expansion.
   localparam logic [STEP_W-1:0] STEP_BYTE_LAST = 4'd1;
   localparam logic [STEP_W-1:0] STEP_INIT_BUS4 = 4'd3;
   localparam logic [STEP_W-1:0] STEP_INIT_CMDS = 4'd4;
   localparam logic [STEP_W-1:0] STEP_INIT_LAST = 4'd11;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // One classified request, as queued between front and back.
   typedef struct packed {
      logic              is_init;
      logic              reg_select;
      logic [BYTE_W-1:0] byte_value;
      logic [1:0]        long_count;
   } desc_type;

   // Command bytes sent after the wake-up nibbles of the init sequence.
   function automatic logic [BYTE_W-1:0] init_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         2'd0:    b = CMD_FUNC_4BIT;
         2'd1:    b = CMD_DISPLAY;
         2'd2:    b = CMD_ENTRY;
         default: b = CMD_CLEAR;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/char_lcd_4bit_interface_unit.sv
`default_nettype none

// Character LCD 4-bit bus sequencer.
// The req channel carries one request: tuser is the kind (command, data, init,
// set cursor, set glyph address, clear), tdata the byte, row, column and slot.
// Each request expands into enable pulses on the rsp channel, one transfer per
// pulse: tuser is register select, tdata holds the nibble and the waits before
// and after the pulse, tlast marks the final pulse of a request.
// The csr channel writes pulse width, settle time and long wait; it is always
// ready and should be written only while no request is in flight.
// A request is classified in the cycle it is accepted and queued; the pulse
// sequencer emits one pulse per cycle while rsp is ready, and each request
// passes the queue and the output register before its first pulse shows.
// Byte requests give two pulses, init twelve; requests queue during expansion.
// Kinds six and seven are accepted and give no pulse.
// When rsp stalls, the output register holds its pulse, the queue fills and
// req_tready falls. Reset empties the queue and the output register and
// restores the register reset values; no clearing pass is needed.
module char_lcd_4bit_interface_unit #(
   parameter int unsigned QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // byte_value, row, column, glyph_slot
   input  wire logic [2:0]  req_tuser,   // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // nibble, wait_before_us, wait_after_us, zero pad
   output logic             rsp_tuser,   // reg_select
   output logic             rsp_tlast,   // last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_data
);
   import clcd_pkg::*;

   logic [PULSE_W-1:0]  pulse_width_ff;
   logic [SETTLE_W-1:0] settle_ff;
   logic [LONG_W-1:0]   long_wait_ff;

   logic                push;
   desc_type            push_desc;
   logic                queue_full;
   logic                pop;
   logic                head_valid;
   desc_type            head_desc;
   logic [NIBBLE_W-1:0] out_nibble;
   logic [WAIT_W-1:0]   out_before;
   logic [WAIT_W-1:0]   out_after;

   // Configuration registers; the pulse width is stored but not used by the sequencer.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff <= PULSE_WIDTH_RESET;
         settle_ff      <= SETTLE_RESET;
         long_wait_ff   <= LONG_WAIT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PULSE_WIDTH: pulse_width_ff <= csr_data[PULSE_W-1:0];
            CSR_SETTLE:      settle_ff      <= csr_data[SETTLE_W-1:0];
            CSR_LONG_WAIT:   long_wait_ff   <= csr_data[LONG_W-1:0];
            default:         pulse_width_ff <= pulse_width_ff;
         endcase
      end
   end

   clcd_front u_front (
      .req_valid  (req_tvalid),
      .req_kind   (req_tuser),
      .req_byte   (req_tdata[7:0]),
      .req_row    (req_tdata[15:8]),
      .req_column (req_tdata[23:16]),
      .req_slot   (req_tdata[31:24]),
      .queue_full (queue_full),
      .req_ready  (req_tready),
      .push       (push),
      .push_desc  (push_desc)
   );

   clcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   clcd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_desc       (head_desc),
      .settle_us       (settle_ff),
      .long_wait_us    (long_wait_ff),
      .pop             (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_reg_select  (rsp_tuser),
      .rsp_nibble      (out_nibble),
      .rsp_wait_before (out_before),
      .rsp_wait_after  (out_after),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {6'b000000, out_after, out_before, out_nibble};

endmodule

`default_nettype wire

// File: rtl/core/clcd_front.sv
`default_nettype none

module clcd_front (
   input  wire logic                    req_valid,
   input  wire logic [2:0]              req_kind,
   input  wire logic [7:0]              req_byte,
   input  wire logic [7:0]              req_row,
   input  wire logic [7:0]              req_column,
   input  wire logic [7:0]              req_slot,
   input  wire logic                    queue_full,
   output logic                         req_ready,
   output logic                         push,
   output clcd_pkg::desc_type           push_desc
);
   import clcd_pkg::*;

   logic [BYTE_W-1:0] cursor_byte;
   logic [BYTE_W-1:0] glyph_byte;
   logic              is_special;

   // Addresses formed by the cursor and glyph requests wrap at eight bits.
   assign cursor_byte = ((req_row == 8'd1) ? LINE1_BASE : LINE2_BASE) + req_column;
   assign glyph_byte  = CGRAM_BASE + {2'b00, req_slot[2:0], 3'b000};

   assign req_ready = !queue_full;

   // Classify the request into a queue descriptor.
   always_comb begin
      push_desc  = '0;
      push       = 1'b0;
      is_special = 1'b0;
      case (kind_type'(req_kind))
         KIND_CMD: begin
            push_desc.byte_value = req_byte;
            push                 = 1'b1;
         end
         KIND_DATA: begin
            push_desc.reg_select = 1'b1;
            push_desc.byte_value = req_byte;
            push                 = 1'b1;
         end
         KIND_INIT: begin
            push_desc.is_init = 1'b1;
            push              = 1'b1;
         end
         KIND_CURSOR: begin
            push_desc.byte_value = cursor_byte;
            push                 = 1'b1;
         end
         KIND_GLYPH: begin
            push_desc.byte_value = glyph_byte;
            push                 = 1'b1;
         end
         KIND_CLEAR: begin
            push_desc.byte_value = CMD_CLEAR;
            is_special           = 1'b1;
            push                 = 1'b1;
         end
         default: begin
            push = 1'b0;
         end
      endcase

      // Clear and home commands need the long wait; an explicit clear adds it again.
      if (!push_desc.is_init && !push_desc.reg_select &&
          (push_desc.byte_value == CMD_CLEAR || push_desc.byte_value == CMD_HOME)) begin
         push_desc.long_count = is_special ? 2'd2 : 2'd1;
      end

      push = push && req_valid && !queue_full;
   end

endmodule

`default_nettype wire

// File: rtl/core/clcd_queue.sv
`default_nettype none

module clcd_queue #(
   parameter int unsigned DEPTH = clcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire clcd_pkg::desc_type push_desc,
   input  wire logic               pop,
   output logic                    full,
   output logic                    head_valid,
   output clcd_pkg::desc_type      head_desc
);
   import clcd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   desc_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("descriptor pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("descriptor popped from an empty queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

// File: rtl/core/clcd_back.sv
`default_nettype none

module clcd_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             head_valid,
   input  wire clcd_pkg::desc_type               head_desc,
   input  wire logic [clcd_pkg::SETTLE_W-1:0]    settle_us,
   input  wire logic [clcd_pkg::LONG_W-1:0]      long_wait_us,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_reg_select,
   output logic [clcd_pkg::NIBBLE_W-1:0]         rsp_nibble,
   output logic [clcd_pkg::WAIT_W-1:0]           rsp_wait_before,
   output logic [clcd_pkg::WAIT_W-1:0]           rsp_wait_after,
   output logic                                  rsp_last
);
   import clcd_pkg::*;

   logic [STEP_W-1:0]   step_ff, step_in;
   logic                valid_ff, valid_in;
   logic                rs_ff;
   logic [NIBBLE_W-1:0] nibble_ff;
   logic [WAIT_W-1:0]   before_ff;
   logic [WAIT_W-1:0]   after_ff;
   logic                last_ff;

   logic                advance;
   logic                is_last_step;
   logic [STEP_W-1:0]   cmd_step;
   logic [BYTE_W-1:0]   cur_byte;
   logic                low_half;
   logic [NIBBLE_W-1:0] pulse_nibble;
   logic [WAIT_W-1:0]   pulse_before;
   extra_type           extra_sel;
   logic [WAIT_W-1:0]   extra_wait;
   logic [WAIT_W-1:0]   pulse_after;

   // A pulse moves into the output register whenever that register frees up.
   assign advance      = head_valid && (!valid_ff || rsp_ready);
   assign is_last_step = head_desc.is_init ? (step_ff == STEP_INIT_LAST)
                                           : (step_ff == STEP_BYTE_LAST);
   assign pop          = advance && is_last_step;
   assign cmd_step     = step_ff - STEP_INIT_CMDS;

   // Describe the pulse for the current step.
   always_comb begin
      cur_byte     = head_desc.byte_value;
      low_half     = step_ff[0];
      pulse_before = '0;
      extra_sel    = EXTRA_NONE;
      pulse_nibble = '0;
      if (head_desc.is_init) begin
         if (step_ff < STEP_INIT_CMDS) begin
            // Wake-up nibbles, then the switch to the 4-bit bus.
            pulse_nibble = (step_ff == STEP_INIT_BUS4) ? BUS4_NIBBLE : WAKE_NIBBLE;
            if (step_ff == '0) begin
               pulse_before = POWER_UP_WAIT;
               extra_sel    = EXTRA_WAKE1;
            end else if (step_ff == STEP_INIT_BUS4 - 4'd2) begin
               extra_sel = EXTRA_WAKE2;
            end
         end else begin
            cur_byte     = init_byte(cmd_step[2:1]);
            pulse_nibble = low_half ? cur_byte[3:0] : cur_byte[7:4];
            if (step_ff == STEP_INIT_LAST) begin
               extra_sel = EXTRA_LONG2;
            end
         end
      end else begin
         pulse_nibble = low_half ? cur_byte[3:0] : cur_byte[7:4];
         if (low_half) begin
            case (head_desc.long_count)
               2'd1:    extra_sel = EXTRA_LONG1;
               2'd2:    extra_sel = EXTRA_LONG2;
               default: extra_sel = EXTRA_NONE;
            endcase
         end
      end
   end

   // Extra wait and the total wait after the pulse.
   always_comb begin
      case (extra_sel)
         EXTRA_WAKE1: extra_wait = WAKE_WAIT1;
         EXTRA_WAKE2: extra_wait = WAKE_WAIT2;
         EXTRA_LONG1: extra_wait = {2'b00, long_wait_us};
         EXTRA_LONG2: extra_wait = {1'b0, long_wait_us, 1'b0};
         default:     extra_wait = '0;
      endcase
   end

   assign pulse_after = {{(WAIT_W - SETTLE_W){1'b0}}, settle_us} + extra_wait;

   // Step counter and output valid.
   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (advance) begin
         step_in  = is_last_step ? '0 : step_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rs_ff     <= head_desc.reg_select;
         nibble_ff <= pulse_nibble;
         before_ff <= pulse_before;
         after_ff  <= pulse_after;
         last_ff   <= is_last_step;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_reg_select  = rs_ff;
   assign rsp_nibble      = nibble_ff;
   assign rsp_wait_before = before_ff;
   assign rsp_wait_after  = after_ff;
   assign rsp_last        = last_ff;

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_INIT_LAST) else $error("expansion step out of range");

   a_step_needs_head: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> head_valid) else $error("request left the queue mid-expansion");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff) else $error("pulse lost on its way to the output");

endmodule

`default_nettype wire
